// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Word layouts, status and operation codes, and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Field widths of the words on the ports
  localparam int PRIO_W   = 16;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 16;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_ENQ_PUT,
    S_DEQ_HEAD,
    S_DEQ_SHIFT
  } state_e;

  // Command word
  typedef struct packed {
    op_e               op;
    logic [PRIO_W-1:0] item_prio;
    logic [DATA_W-1:0] item_data;
  } item_t;

  // Result word
  typedef struct packed {
    logic [PRIO_W-1:0]  out_prio;
    logic [DATA_W-1:0]  out_data;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-array priority queue
// Entries kept in ascending priority order in one RAM; a sequencer shifts
// entries one slot per cycle on insert and on removal of the head.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  handshake
//  command   start, busy, item_i             in         start & !busy
//  result    result_valid_o, result_o        out        one-cycle strobe
//  config    cfg_we_i, cfg_wdata_i           in         write enable
//
//  A rejected word is answered from the idle state. Enqueue and dequeue
//  lengths grow with the entries to move and are set by the single RAM
//  read port: one entry moves per cycle. The result appears the cycle
//  after the last step.
//  Reset empties the queue and sets capacity to 16; the RAM is not cleared.
//  The receiver cannot stall; busy is high while a word is in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire spq_pkg::item_t              item_i,
  output logic                             result_valid_o,
  output spq_pkg::result_t                 result_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [spq_pkg::CAP_W-1:0]   cfg_wdata_i
);

  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
  localparam int EW = PW + DATA_W;
  localparam int LW = (FW > CAP_W) ? FW : CAP_W;

  state_e            state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     ptr_q, ptr_d;
  logic [CAP_W-1:0]  cap_q;
  logic [EW-1:0]     entry_q, entry_d;
  result_t           res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  logic [LW-1:0]     cap_ext;
  logic [LW-1:0]     limit;
  logic              full;
  logic [EW-1:0]     new_entry;

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    cap_ext = LW'(cap_q);
    if (cap_ext == '0) begin
      limit = LW'(1);
    end else if (cap_ext > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = cap_ext;
    end
    full = (LW'(fill_q) >= limit);
  end

  assign new_entry = {item_i.item_prio[PW-1:0], item_i.item_data};

  // entry store
  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer: next state, RAM control, result
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    entry_d     = entry_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = entry_q;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          entry_d = new_entry;
          if (item_i.op == OP_ENQ) begin
            if (full) begin
              res_valid_d    = 1'b1;
              res_d.out_prio = '0;
              res_d.out_data = '0;
              res_d.status   = ST_FULL;
              res_d.count    = COUNT_W'(fill_q);
            end else if (fill_q == '0) begin
              // empty queue: write straight to the head slot
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = new_entry;
              fill_d         = FW'(1);
              res_valid_d    = 1'b1;
              res_d.out_prio = '0;
              res_d.out_data = '0;
              res_d.status   = ST_DONE;
              res_d.count    = COUNT_W'(fill_d);
            end else begin
              ram_raddr = AW'(fill_q - FW'(1));
              ptr_d     = fill_q;
              state_d   = S_ENQ_SCAN;
            end
          end else begin
            if (fill_q == '0) begin
              res_valid_d    = 1'b1;
              res_d.out_prio = '0;
              res_d.out_data = '0;
              res_d.status   = ST_EMPTY;
              res_d.count    = COUNT_W'(fill_q);
            end else begin
              ram_raddr = '0;
              state_d   = S_DEQ_HEAD;
            end
          end
        end
      end

      // walk down from the tail; move larger entries up one slot
      S_ENQ_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_q);
        if (ram_rdata[EW-1:DATA_W] > entry_q[EW-1:DATA_W]) begin
          ram_wdata = ram_rdata;
          ptr_d     = ptr_q - FW'(1);
          if (ptr_q == FW'(1)) begin
            state_d = S_ENQ_PUT;
          end else begin
            ram_raddr = AW'(ptr_q - FW'(2));
          end
        end else begin
          ram_wdata      = entry_q;
          fill_d         = fill_q + FW'(1);
          res_valid_d    = 1'b1;
          res_d.out_prio = '0;
          res_d.out_data = '0;
          res_d.status   = ST_DONE;
          res_d.count    = COUNT_W'(fill_d);
          state_d        = S_IDLE;
        end
      end

      // new entry goes to the head slot
      S_ENQ_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = entry_q;
        fill_d         = fill_q + FW'(1);
        res_valid_d    = 1'b1;
        res_d.out_prio = '0;
        res_d.out_data = '0;
        res_d.status   = ST_DONE;
        res_d.count    = COUNT_W'(fill_d);
        state_d        = S_IDLE;
      end

      // head entry arrives from the RAM
      S_DEQ_HEAD: begin
        entry_d = ram_rdata;
        if (fill_q == FW'(1)) begin
          fill_d         = '0;
          res_valid_d    = 1'b1;
          res_d.out_prio = PRIO_W'(ram_rdata[EW-1:DATA_W]);
          res_d.out_data = ram_rdata[DATA_W-1:0];
          res_d.status   = ST_DONE;
          res_d.count    = COUNT_W'(fill_d);
          state_d        = S_IDLE;
        end else begin
          ram_raddr = AW'(1);
          ptr_d     = FW'(1);
          state_d   = S_DEQ_SHIFT;
        end
      end

      // move each remaining entry down one slot
      S_DEQ_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_q - FW'(1));
        ram_wdata = ram_rdata;
        if (ptr_q + FW'(1) == fill_q) begin
          fill_d         = fill_q - FW'(1);
          res_valid_d    = 1'b1;
          res_d.out_prio = PRIO_W'(entry_q[EW-1:DATA_W]);
          res_d.out_data = entry_q[DATA_W-1:0];
          res_d.status   = ST_DONE;
          res_d.count    = COUNT_W'(fill_d);
          state_d        = S_IDLE;
        end else begin
          ram_raddr = AW'(ptr_q + FW'(1));
          ptr_d     = ptr_q + FW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      cap_q       <= CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire
